/* rtl/vrgs_pkg.sv */
// Shared types, widths and constants of the greedy route splitter.
`default_nettype none

package vrgs_pkg;

    // Fixed-point fraction bits of every distance.
    localparam int FRAC_BITS = 8;

    localparam int COORD_W    = 11;
    localparam int DIST_W     = 24;
    localparam int LOAD_W     = 16;
    localparam int LOADX_W    = LOAD_W + 1;
    localparam int QTY_W      = 12;
    localparam int STOPS_W    = 12;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // A coordinate difference squared fits in 22 bits, the sum of two in 23.
    localparam int SQ_W  = 22;
    localparam int SUM_W = SQ_W + 1;

    // The root unit resolves two result bits per cycle, so its width is even.
    localparam int ROOT_W = 2 * ((SUM_W + 2 * FRAC_BITS + 3) / 4);
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int ITER   = ROOT_W / 2;
    localparam int ITER_W = $clog2(ITER);

    // Candidate route length: three distances added, one subtracted, signed.
    localparam int CAND_W = DIST_W + 3;

    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [LOAD_W-1:0]  LOAD_MAX  = {LOAD_W{1'b1}};
    localparam logic [STOPS_W-1:0] STOPS_MAX = {STOPS_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SVC  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLOSED    = 2'd0,
        ST_FIRST_BAD = 2'd1,
        ST_NEW_BAD   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_LOOP,
        S_GO_LOOP,
        S_WAIT_LOOP,
        S_SQ_LEG,
        S_GO_LEG,
        S_WAIT_LEG,
        S_SUM,
        S_DECIDE,
        S_EMIT0,
        S_EMIT1
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic sq_load;
        logic leg_sel;
        logic root_start;
        logic loop_save;
        logic leg_save;
        logic sum_load;
        logic decide;
        logic out_load;
        logic out_sel;
    } vrgs_cmd_t;

    typedef struct packed {
        logic       failed;
        logic       root_done;
        logic [1:0] res_cnt;
    } vrgs_stat_t;

    typedef struct packed {
        status_t              status;
        logic [DIST_W-1:0]    length;
        logic [LOAD_W-1:0]    load;
        logic [LOAD_W-1:0]    service;
        logic [STOPS_W-1:0]   stops;
    } vrgs_res_t;

endpackage

`default_nettype wire

/* rtl/vrgs_sqrt.sv */
// Iterative integer square root, two result bits per cycle.
`default_nettype none

module vrgs_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [vrgs_pkg::RAD_W-1:0] radicand,
    output logic                            done,
    output logic [vrgs_pkg::ROOT_W-1:0]     root
);
    import vrgs_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [RAD_W-1:0]  rad_s  [0:2];
    logic [REM_W-1:0]  rem_s  [0:2];
    logic [ROOT_W-1:0] root_s [0:2];
    logic [REM_W-1:0]  cand   [0:1];
    logic [REM_W-1:0]  trial  [0:1];

    // Two digit steps of the classic restoring root per clock.
    always_comb
    begin
        rad_s[0]  = rad_reg;
        rem_s[0]  = rem_reg;
        root_s[0] = root_reg;
        for (int k = 0; k < 2; k++)
        begin
            cand[k]  = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
            trial[k] = REM_W'({root_s[k], 2'b01});
            if (cand[k] >= trial[k])
            begin
                rem_s[k+1]  = cand[k] - trial[k];
                root_s[k+1] = {root_s[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_s[k+1]  = cand[k];
                root_s[k+1] = {root_s[k][ROOT_W-2:0], 1'b0};
            end
            rad_s[k+1] = rad_s[k] << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == ITER_W'(ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_s[2];
            rem_reg  <= rem_s[2];
            root_reg <= root_s[2];
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* rtl/vrgs_datapath.sv */
// Datapath: configuration, list state, distances, limit checks and result registers.
`default_nettype none

module vrgs_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [vrgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vrgs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic signed [vrgs_pkg::COORD_W-1:0] cust_x,
    input  wire logic signed [vrgs_pkg::COORD_W-1:0] cust_y,
    input  wire logic [vrgs_pkg::QTY_W-1:0]      demand,
    input  wire logic [vrgs_pkg::QTY_W-1:0]      service_time,
    input  wire logic                            list_end,
    input  wire vrgs_pkg::vrgs_cmd_t             cmd,
    output vrgs_pkg::vrgs_stat_t                 stat,
    output logic [vrgs_pkg::STATUS_W-1:0]        status,
    output logic [vrgs_pkg::DIST_W-1:0]          route_length,
    output logic [vrgs_pkg::LOAD_W-1:0]          route_load,
    output logic [vrgs_pkg::LOAD_W-1:0]          route_service,
    output logic [vrgs_pkg::STOPS_W-1:0]         route_stops,
    output logic                                 last
);
    import vrgs_pkg::*;

    // Configuration registers.
    logic signed [COORD_W-1:0] depot_x_reg, depot_y_reg;
    logic [DIST_W-1:0]         max_len_reg;
    logic [LOAD_W-1:0]         max_load_reg, max_svc_reg;

    // Customer held for the duration of its work.
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic [QTY_W-1:0]          dem_reg, svc_reg;
    logic                      end_reg;

    // List state.
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [DIST_W-1:0]         prev_leg_reg;
    logic [DIST_W-1:0]         acc_len_reg;
    logic [LOAD_W-1:0]         acc_load_reg, acc_svc_reg;
    logic [STOPS_W-1:0]        acc_stops_reg;
    logic                      failed_reg, at_start_reg;

    // Working registers.
    logic [SQ_W-1:0]           sq_x_reg, sq_y_reg;
    logic [DIST_W-1:0]         loop_reg, leg_reg;
    logic signed [CAND_W-1:0]  cand_len_reg;
    logic [LOADX_W-1:0]        cand_load_reg, cand_svc_reg;
    vrgs_res_t                 res0_reg, res1_reg, out_res_reg;
    logic [1:0]                res_cnt_reg;
    logic                      last_reg;

    logic signed [COORD_W-1:0]   px, py;
    logic signed [COORD_W:0]     dx, dy;
    logic signed [2*COORD_W+1:0] dx_sq, dy_sq;
    logic [SUM_W-1:0]            sq_sum;
    logic [RAD_W-1:0]            radicand;
    logic [ROOT_W-1:0]           root;
    logic                        root_done;
    logic [DIST_W-1:0]           dist_val;
    logic [DIST_W-1:0]           pleg;

    logic                over, new_bad;
    logic [DIST_W:0]     two;
    logic [DIST_W-1:0]   two_sat, len_sat;
    logic [LOAD_W-1:0]   load_sat, svc_sat;
    logic [STOPS_W-1:0]  stops_inc;
    vrgs_res_t           acc_n, res0_n, res1_n;
    logic [1:0]          cnt_n;
    logic                fail_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depot_x_reg  <= '0;
            depot_y_reg  <= '0;
            max_len_reg  <= '0;
            max_load_reg <= LOAD_MAX;
            max_svc_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEPOT_X:  depot_x_reg  <= cfg_data[COORD_W-1:0];
                CFG_DEPOT_Y:  depot_y_reg  <= cfg_data[COORD_W-1:0];
                CFG_MAX_LEN:  max_len_reg  <= cfg_data[DIST_W-1:0];
                CFG_MAX_LOAD: max_load_reg <= cfg_data[LOAD_W-1:0];
                CFG_MAX_SVC:  max_svc_reg  <= cfg_data[LOAD_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cx_reg  <= cust_x;
            cy_reg  <= cust_y;
            dem_reg <= demand;
            svc_reg <= service_time;
            end_reg <= list_end;
        end
    end

    // Squares of the coordinate differences; the leg pass measures from the previous stop.
    always_comb
    begin
        if (cmd.leg_sel && !at_start_reg)
        begin
            px = prev_x_reg;
            py = prev_y_reg;
        end
        else
        begin
            px = depot_x_reg;
            py = depot_y_reg;
        end
    end

    assign dx    = {cx_reg[COORD_W-1], cx_reg} - {px[COORD_W-1], px};
    assign dy    = {cy_reg[COORD_W-1], cy_reg} - {py[COORD_W-1], py};
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
        begin
            sq_x_reg <= dx_sq[SQ_W-1:0];
            sq_y_reg <= dy_sq[SQ_W-1:0];
        end
    end

    assign sq_sum   = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign radicand = RAD_W'(sq_sum) << (2 * FRAC_BITS);

    vrgs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    // The root never exceeds 24 bits over the whole fraction range.
    assign dist_val = DIST_W'(root);

    always_ff @(posedge clk)
    begin
        if (cmd.loop_save)
        begin
            loop_reg <= dist_val;
        end
        if (cmd.leg_save)
        begin
            leg_reg <= dist_val;
        end
    end

    assign pleg = at_start_reg ? '0 : prev_leg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            cand_len_reg  <= CAND_W'(acc_len_reg) + CAND_W'(leg_reg)
                           + CAND_W'(loop_reg) - CAND_W'(pleg);
            cand_load_reg <= LOADX_W'(acc_load_reg) + LOADX_W'(dem_reg);
            cand_svc_reg  <= LOADX_W'(acc_svc_reg) + LOADX_W'(svc_reg);
        end
    end

    // Limit checks and saturation of the candidate totals.
    assign over = ((max_len_reg != '0) && (cand_len_reg > $signed(CAND_W'(max_len_reg))))
               || (cand_load_reg > LOADX_W'(max_load_reg))
               || ((max_svc_reg != '0) && (cand_svc_reg > LOADX_W'(max_svc_reg)));

    assign two     = {loop_reg, 1'b0};
    assign two_sat = two[DIST_W] ? DIST_MAX : two[DIST_W-1:0];

    assign new_bad = ((max_len_reg != '0) && (two > {1'b0, max_len_reg}))
                  || (LOAD_W'(dem_reg) > max_load_reg)
                  || ((max_svc_reg != '0) && (LOAD_W'(svc_reg) > max_svc_reg));

    always_comb
    begin
        if (cand_len_reg[CAND_W-1])
        begin
            len_sat = '0;
        end
        else if (|cand_len_reg[CAND_W-2:DIST_W])
        begin
            len_sat = DIST_MAX;
        end
        else
        begin
            len_sat = cand_len_reg[DIST_W-1:0];
        end
    end

    assign load_sat  = cand_load_reg[LOAD_W] ? LOAD_MAX : cand_load_reg[LOAD_W-1:0];
    assign svc_sat   = cand_svc_reg[LOAD_W] ? LOAD_MAX : cand_svc_reg[LOAD_W-1:0];
    assign stops_inc = (acc_stops_reg == STOPS_MAX) ? acc_stops_reg : acc_stops_reg + 1'b1;

    always_comb
    begin
        acc_n  = '{ST_CLOSED, acc_len_reg, acc_load_reg, acc_svc_reg, acc_stops_reg};
        res0_n = '{ST_CLOSED, '0, '0, '0, '0};
        res1_n = '{ST_CLOSED, '0, '0, '0, '0};
        cnt_n  = 2'd0;
        fail_n = failed_reg;
        if (over)
        begin
            if (acc_stops_reg == '0)
            begin
                res0_n = '{ST_FIRST_BAD, '0, '0, '0, '0};
                cnt_n  = 2'd1;
                fail_n = 1'b1;
            end
            else
            begin
                // Close the open route and start a new one with this customer alone.
                res0_n = acc_n;
                acc_n  = '{ST_CLOSED, two_sat, LOAD_W'(dem_reg), LOAD_W'(svc_reg),
                           STOPS_W'(1)};
                cnt_n  = 2'd1;
                if (new_bad)
                begin
                    res1_n = '{ST_NEW_BAD, '0, '0, '0, '0};
                    cnt_n  = 2'd2;
                    fail_n = 1'b1;
                end
            end
        end
        else
        begin
            acc_n = '{ST_CLOSED, len_sat, load_sat, svc_sat, stops_inc};
        end

        // At the end of the list a route still open is closed as well.
        if (end_reg && !fail_n && (acc_n.stops != '0))
        begin
            if (cnt_n == 2'd0)
            begin
                res0_n = acc_n;
                cnt_n  = 2'd1;
            end
            else
            begin
                res1_n = acc_n;
                cnt_n  = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_leg_reg  <= '0;
            acc_len_reg   <= '0;
            acc_load_reg  <= '0;
            acc_svc_reg   <= '0;
            acc_stops_reg <= '0;
            failed_reg    <= 1'b0;
            at_start_reg  <= 1'b1;
            res_cnt_reg   <= 2'd0;
        end
        else if ((cmd.accept && failed_reg && list_end) || (cmd.decide && end_reg))
        begin
            prev_x_reg    <= depot_x_reg;
            prev_y_reg    <= depot_y_reg;
            prev_leg_reg  <= '0;
            acc_len_reg   <= '0;
            acc_load_reg  <= '0;
            acc_svc_reg   <= '0;
            acc_stops_reg <= '0;
            failed_reg    <= 1'b0;
            at_start_reg  <= 1'b1;
            if (cmd.decide)
            begin
                res_cnt_reg <= cnt_n;
            end
        end
        else if (cmd.decide)
        begin
            prev_x_reg    <= cx_reg;
            prev_y_reg    <= cy_reg;
            prev_leg_reg  <= loop_reg;
            acc_len_reg   <= acc_n.length;
            acc_load_reg  <= acc_n.load;
            acc_svc_reg   <= acc_n.service;
            acc_stops_reg <= acc_n.stops;
            failed_reg    <= fail_n;
            at_start_reg  <= 1'b0;
            res_cnt_reg   <= cnt_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            res0_reg <= res0_n;
            res1_reg <= res1_n;
        end
        if (cmd.out_load)
        begin
            out_res_reg <= cmd.out_sel ? res1_reg : res0_reg;
            last_reg    <= cmd.out_sel || (res_cnt_reg == 2'd1);
        end
    end

    assign stat.failed    = failed_reg;
    assign stat.root_done = root_done;
    assign stat.res_cnt   = res_cnt_reg;

    assign status        = out_res_reg.status;
    assign route_length  = out_res_reg.length;
    assign route_load    = out_res_reg.load;
    assign route_service = out_res_reg.service;
    assign route_stops   = out_res_reg.stops;
    assign last          = last_reg;

endmodule

`default_nettype wire

/* rtl/vrgs_ctrl.sv */
// Controller: sequences one customer through the datapath and drives both handshakes.
`default_nettype none

module vrgs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire vrgs_pkg::vrgs_stat_t stat,
    output vrgs_pkg::vrgs_cmd_t       cmd
);
    import vrgs_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !stat.failed)
                begin
                    state_next = S_SQ_LOOP;
                end
            end
            S_SQ_LOOP:   state_next = S_GO_LOOP;
            S_GO_LOOP:   state_next = S_WAIT_LOOP;
            S_WAIT_LOOP:
            begin
                if (stat.root_done)
                begin
                    state_next = S_SQ_LEG;
                end
            end
            S_SQ_LEG:    state_next = S_GO_LEG;
            S_GO_LEG:    state_next = S_WAIT_LEG;
            S_WAIT_LEG:
            begin
                if (stat.root_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:       state_next = S_DECIDE;
            S_DECIDE:    state_next = S_EMIT0;
            S_EMIT0:
            begin
                if (stat.res_cnt == 2'd0)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    state_next = (stat.res_cnt == 2'd2) ? S_EMIT1 : S_IDLE;
                end
            end
            S_EMIT1:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_SQ_LOOP:   cmd.sq_load = 1'b1;
            S_GO_LOOP:   cmd.root_start = 1'b1;
            S_WAIT_LOOP: cmd.loop_save = stat.root_done;
            S_SQ_LEG:
            begin
                cmd.sq_load = 1'b1;
                cmd.leg_sel = 1'b1;
            end
            S_GO_LEG:    cmd.root_start = 1'b1;
            S_WAIT_LEG:  cmd.leg_save = stat.root_done;
            S_SUM:       cmd.sum_load = 1'b1;
            S_DECIDE:    cmd.decide = 1'b1;
            S_EMIT0:     cmd.out_load = out_free && (stat.res_cnt != 2'd0);
            S_EMIT1:
            begin
                cmd.out_load = out_free;
                cmd.out_sel  = 1'b1;
            end
            default:     ;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_root_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_start |=> !stat.root_done)
        else $error("root unit finished one cycle after start");

    a_emit1_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT1) |-> (stat.res_cnt == 2'd2))
        else $error("second result emitted without two pending");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

/* rtl/vehicle_route_greedy_split.sv */
// Top level of the greedy vehicle route splitter.
// Usage: configure the depot position and the route limits through the write port
// while the block is idle, then send one depot's customers in order, one item per
// customer, with list_end high on the last one. Each customer yields zero, one or
// two result items: a closed route with its length, load, service time and stop
// count, or an error status when a customer cannot start a route; after an error
// the rest of the list is dropped silently. The last result item of a customer
// carries last high.
// Sequence: after a customer is accepted, out_valid rises once both root runs, the
// sum and the decision are done. The shared root unit resolves two root bits per
// cycle and runs twice (depot leg and previous-stop leg), with sequencing states
// around the runs. With a ready receiver the next customer is accepted once the
// results are emitted; a second result adds an emit state. A customer after an error
// is consumed without being worked on. in_ready is high only between customers.
// The output register decouples the sides: while a single result waits on a stalled
// receiver the next customer is already accepted and worked on; only the emission of
// its results waits for the output register to free. While the first of two results
// waits, the second result and the input wait with it.
// Reset puts the registers at their reset values and starts an empty list.
`default_nettype none

module vehicle_route_greedy_split (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [vrgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vrgs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [vrgs_pkg::COORD_W-1:0] cust_x,
    input  wire logic signed [vrgs_pkg::COORD_W-1:0] cust_y,
    input  wire logic [vrgs_pkg::QTY_W-1:0]      demand,
    input  wire logic [vrgs_pkg::QTY_W-1:0]      service_time,
    input  wire logic                            list_end,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [vrgs_pkg::STATUS_W-1:0]        status,
    output logic [vrgs_pkg::DIST_W-1:0]          route_length,
    output logic [vrgs_pkg::LOAD_W-1:0]          route_load,
    output logic [vrgs_pkg::LOAD_W-1:0]          route_service,
    output logic [vrgs_pkg::STOPS_W-1:0]         route_stops,
    output logic                                 last
);
    import vrgs_pkg::*;

    // Commands from the controller and status back from the datapath.
    vrgs_cmd_t  cmd;
    vrgs_stat_t stat;

    // The controller owns both handshakes and the sequence of one customer.
    vrgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds configuration, the open route and the result registers.
    vrgs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cust_x        (cust_x),
        .cust_y        (cust_y),
        .demand        (demand),
        .service_time  (service_time),
        .list_end      (list_end),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .route_length  (route_length),
        .route_load    (route_load),
        .route_service (route_service),
        .route_stops   (route_stops),
        .last          (last)
    );

endmodule

`default_nettype wire

/* test/vehicle_route_greedy_split_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the greedy vehicle route splitter, with its own route predictor.

module vehicle_route_greedy_split_test;

    import vrgs_pkg::*;

    // The run is ended here if it has not finished by itself.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Once this many customers have been taken, the receiver holds off for a long stretch.
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 300;
    // This margin covers customers that cause no result.
    localparam int SETTLE_CYCLES = 60;

    // One customer as it is offered to the block.
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [QTY_W-1:0]          demand;
        logic [QTY_W-1:0]          service;
        bit                        list_end;
    } cust_t;

    // One route result item as the block should report it.
    typedef struct {
        status_t             status;
        logic [DIST_W-1:0]   length;
        logic [LOAD_W-1:0]   load;
        logic [LOAD_W-1:0]   service;
        logic [STOPS_W-1:0]  stops;
        bit                  last;
    } route_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                         cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;

    logic                         in_valid     = 1'b0;
    logic                         in_ready;
    logic signed [COORD_W-1:0]    cust_x       = '0;
    logic signed [COORD_W-1:0]    cust_y       = '0;
    logic [QTY_W-1:0]             demand       = '0;
    logic [QTY_W-1:0]             service_time = '0;
    logic                         list_end     = 1'b0;

    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [STATUS_W-1:0]          status;
    logic [DIST_W-1:0]            route_length;
    logic [LOAD_W-1:0]            route_load;
    logic [LOAD_W-1:0]            route_service;
    logic [STOPS_W-1:0]           route_stops;
    logic                         last;

    // Customers waiting to be offered, and the routes the block still owes us.
    cust_t  customer_q[$];
    route_t pending_routes[$];
    cust_t  cur_cust;

    int issued_total   = 0;
    int accepted_total = 0;
    int err_count      = 0;
    int cycle_count    = 0;
    // Set for the last part of the run, where neither side idles.
    bit calm = 1'b0;

    // Register values as the predictor sees them, starting at their reset values.
    int     home_x      = 0;
    int     home_y      = 0;
    longint length_cap  = 0;
    int     load_cap    = 65535;
    int     service_cap = 0;

    // Predictor state of the list that is being split.
    int     prev_stop_x   = 0;
    int     prev_stop_y   = 0;
    longint prev_home_leg = 0;
    longint open_length   = 0;
    int     open_load     = 0;
    int     open_service  = 0;
    int     open_stops    = 0;
    bit     list_dropped  = 1'b0;
    bit     list_fresh    = 1'b1;

    vehicle_route_greedy_split i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cust_x        (cust_x),
        .cust_y        (cust_y),
        .demand        (demand),
        .service_time  (service_time),
        .list_end      (list_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .route_length  (route_length),
        .route_load    (route_load),
        .route_service (route_service),
        .route_stops   (route_stops),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Euclidean distance in fixed point, rounded down. The root is built one bit at a
    // time from the top, keeping each bit whose square still fits under the radicand.
    function automatic longint fixed_dist(int ax, int ay, int bx, int by);
        longint unsigned rad;
        longint unsigned root;
        longint unsigned trial;
        rad  = longint'((ax - bx) * (ax - bx) + (ay - by) * (ay - by)) << (2 * FRAC_BITS);
        root = 0;
        for (int b = 25; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= rad)
                root = trial;
        end
        return (root > longint'(DIST_MAX)) ? longint'(DIST_MAX) : longint'(root);
    endfunction

    function automatic void note_route(status_t st, longint len, int ld, int sv, int sp);
        route_t r;
        r.status  = st;
        r.length  = len[DIST_W-1:0];
        r.load    = ld[LOAD_W-1:0];
        r.service = sv[LOAD_W-1:0];
        r.stops   = sp[STOPS_W-1:0];
        r.last    = 1'b0;
        pending_routes.insert(pending_routes.size(), r);
    endfunction

    // A new list starts from the depot with an empty route.
    function automatic void restart_list();
        prev_stop_x   = home_x;
        prev_stop_y   = home_y;
        prev_home_leg = 0;
        open_length   = 0;
        open_load     = 0;
        open_service  = 0;
        open_stops    = 0;
        list_dropped  = 1'b0;
        list_fresh    = 1'b1;
    endfunction

    // Works out the route items that one accepted customer causes and queues them.
    function automatic void split_customer(cust_t c);
        int     cx, cy, px, py, dem, svc, owed_before, cand_load, cand_svc;
        longint home_leg, hop, pleg, cand_len, fresh_len, dist_top;
        bit     over;
        route_t tail;
        cx          = int'(c.x);
        cy          = int'(c.y);
        dem         = int'(c.demand);
        svc         = int'(c.service);
        owed_before = pending_routes.size();
        dist_top    = longint'(DIST_MAX);

        // After an error the rest of the list is swallowed; its end starts a new list.
        if (list_dropped)
        begin
            if (c.list_end)
                restart_list();
            return;
        end

        px       = list_fresh ? home_x : prev_stop_x;
        py       = list_fresh ? home_y : prev_stop_y;
        pleg     = list_fresh ? 0 : prev_home_leg;
        home_leg = fixed_dist(cx, cy, home_x, home_y);
        hop      = fixed_dist(cx, cy, px, py);
        prev_stop_x   = cx;
        prev_stop_y   = cy;
        prev_home_leg = home_leg;
        list_fresh    = 1'b0;

        // The delta may come out negative through rounding, so the sum is kept signed.
        cand_len  = open_length + hop + home_leg - pleg;
        cand_load = open_load + dem;
        cand_svc  = open_service + svc;
        over = (length_cap != 0 && cand_len > length_cap) || cand_load > load_cap
            || (service_cap != 0 && cand_svc > service_cap);

        if (over)
        begin
            if (open_stops == 0)
            begin
                note_route(ST_FIRST_BAD, 0, 0, 0, 0);
                list_dropped = 1'b1;
            end
            else
            begin
                note_route(ST_CLOSED, open_length, open_load, open_service, open_stops);
                // The new route goes out to this customer and back; its service time
                // is counted once only.
                fresh_len    = 2 * home_leg;
                open_length  = (fresh_len > dist_top) ? dist_top : fresh_len;
                open_load    = dem;
                open_service = svc;
                open_stops   = 1;
                if ((length_cap != 0 && fresh_len > length_cap) || dem > load_cap
                    || (service_cap != 0 && svc > service_cap))
                begin
                    note_route(ST_NEW_BAD, 0, 0, 0, 0);
                    list_dropped = 1'b1;
                end
            end
        end
        else
        begin
            open_length  = (cand_len < 0) ? 0 : ((cand_len > dist_top) ? dist_top : cand_len);
            open_load    = (cand_load > 65535) ? 65535 : cand_load;
            open_service = (cand_svc > 65535) ? 65535 : cand_svc;
            if (open_stops < 4095)
                open_stops++;
        end

        if (c.list_end)
        begin
            if (!list_dropped && open_stops > 0)
                note_route(ST_CLOSED, open_length, open_load, open_service, open_stops);
            restart_list();
        end

        if (pending_routes.size() > owed_before)
        begin
            tail      = pending_routes.pop_back();
            tail.last = 1'b1;
            pending_routes.insert(pending_routes.size(), tail);
        end
    endfunction

    // A coordinate near the given centre, or anywhere once the spread covers the field.
    function automatic int pick_coord(int centre, int spread);
        int v;
        if (spread >= 1024)
            return int'($urandom_range(0, 2047)) - 1024;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        return (v < -1024) ? -1024 : ((v > 1023) ? 1023 : v);
    endfunction

    // Mostly quantities that let a few customers share a route, now and then the extremes.
    function automatic int pick_qty(int cap);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return int'($urandom_range(0, 4095));
            2: return 4095;
            default: return int'($urandom_range(0, (cap / 4 > 4095) ? 4095 : cap / 4));
        endcase
    endfunction

    task automatic offer(input int x, input int y, input int dem, input int svc, input bit fin);
        cust_t c;
        c.x        = x[COORD_W-1:0];
        c.y        = y[COORD_W-1:0];
        c.demand   = dem[QTY_W-1:0];
        c.service  = svc[QTY_W-1:0];
        c.list_end = fin;
        customer_q.insert(customer_q.size(), c);
        issued_total++;
    endtask

    // Writes every register, one per cycle, and mirrors the values in the predictor.
    task automatic apply_config(input int dx, input int dy, input int len, input int ld,
                                input int sv);
        int                   vals[5];
        logic [CFG_IDX_W-1:0] idxs[5];
        vals = '{dx, dy, len, ld, sv};
        idxs = '{CFG_DEPOT_X, CFG_DEPOT_Y, CFG_MAX_LEN, CFG_MAX_LOAD, CFG_MAX_SVC};
        for (int k = 0; k < 5; k++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idxs[k];
            cfg_data  <= vals[k][CFG_DATA_W-1:0];
        end
        @(posedge clk);
        cfg_we      <= 1'b0;
        home_x      = dx;
        home_y      = dy;
        length_cap  = len;
        load_cap    = ld;
        service_cap = sv;
    endtask

    // Waits until every customer has been taken and every owed route has come back,
    // then gives the block time to finish customers that cause no result.
    task automatic settle();
        do
            @(posedge clk);
        while (accepted_total != issued_total || pending_routes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Queues whole customer lists with random content around the current depot. Now and
    // then a list is left without its end, so that it runs on into the next one.
    task automatic random_lists(input int count, input int max_run);
        int run, spread, scap, made;
        bit fin;
        made = 0;
        scap = (service_cap == 0) ? 65535 : service_cap;
        while (made < count)
        begin
            run    = $urandom_range(1, max_run);
            spread = ($urandom_range(0, 3) == 0) ? 2047 : $urandom_range(0, 120);
            for (int k = 0; k < run; k++)
            begin
                fin = (k == run - 1) && ($urandom_range(0, 11) != 0);
                offer(pick_coord(home_x, spread), pick_coord(home_y, spread),
                      pick_qty(load_cap), pick_qty(scap), fin);
            end
            made += run;
        end
    endtask

    // Sender side. The customer on the port is run through the predictor at the edge at
    // which the block takes it; the next one follows at once unless a short idle burst
    // is rolled.
    int  gap_left;
    bit  took;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            took = in_valid && in_ready;
            if (took)
            begin
                split_customer(cur_cust);
                accepted_total++;
            end
            if (!in_valid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (customer_q.size() > 0 && !calm && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else if (customer_q.size() > 0)
                begin
                    cur_cust = customer_q.pop_front();
                    in_valid     <= 1'b1;
                    cust_x       <= cur_cust.x;
                    cust_y       <= cur_cust.y;
                    demand       <= cur_cust.demand;
                    service_time <= cur_cust.service;
                    list_end     <= cur_cust.list_end;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side. Short stall bursts at random, plus one long hold-off that lets the
    // block fill up and stop taking customers while the sender keeps offering them.
    int stall_left;
    int hold_left;
    bit long_hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (!long_hold_done && accepted_total >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every route item taken from the block is checked against the oldest one owed.
    always @(posedge clk)
    begin : watch_routes
        route_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_routes.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected route item: status %0d length %0d load %0d",
                             status, route_length, route_load);
            end
            else
            begin
                want = pending_routes.pop_front();
                if (status !== want.status || route_length !== want.length
                    || route_load !== want.load || route_service !== want.service
                    || route_stops !== want.stops || last !== want.last)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"route mismatch: expected st %0d len %0d load %0d svc %0d",
                                  " stops %0d last %0b, got st %0d len %0d load %0d svc %0d",
                                  " stops %0d last %0b"},
                                 want.status, want.length, want.load, want.service,
                                 want.stops, want.last, status, route_length, route_load,
                                 route_service, route_stops, last);
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Unlimited routes: the coordinate extremes, a return to the depot, a detour that
        // rounds to a negative length delta, and a customer at the depot itself.
        apply_config(0, 0, 0, 65535, 0);
        offer(1023, 1023, 4095, 4095, 1'b0);
        offer(-1024, -1024, 4095, 4095, 1'b0);
        offer(-1024, 1023, 0, 0, 1'b0);
        offer(1023, -1024, 0, 0, 1'b1);
        offer(3, 6, 1, 1, 1'b0);
        offer(1, 2, 1, 1, 1'b1);
        offer(0, 0, 0, 0, 1'b1);
        settle();

        // Tight limits: a close on load, a close on service where the new route sits
        // exactly on the limit, a new route that cannot stand alone, a dropped tail,
        // first customers refused on load, length and service, and a close together
        // with the end of the list.
        apply_config(0, 0, 8192, 1000, 100);
        offer(5, 0, 400, 50, 1'b0);
        offer(-5, 0, 400, 40, 1'b0);
        offer(0, 5, 400, 10, 1'b0);
        offer(0, -5, 100, 100, 1'b0);
        offer(0, -1, 2000, 0, 1'b0);
        offer(1, 1, 0, 0, 1'b0);
        offer(2, 2, 0, 0, 1'b1);
        offer(0, 20, 1200, 0, 1'b1);
        offer(0, 17, 0, 0, 1'b0);
        offer(0, 0, 0, 0, 1'b1);
        offer(0, 0, 0, 101, 1'b1);
        offer(3, 4, 10, 10, 1'b0);
        offer(0, 16, 10, 10, 1'b1);
        settle();

        // Register extremes: the depot in a corner, the widest length limit and no load.
        apply_config(-1024, -1024, 16777215, 0, 65535);
        offer(1023, 1023, 0, 4095, 1'b0);
        offer(-1024, -1024, 1, 0, 1'b0);
        offer(1023, -1024, 0, 0, 1'b1);
        offer(0, 0, 0, 0, 1'b1);
        settle();

        // Random lists with the depot in a corner under fixed limits.
        apply_config(1023, 1023, 300000, 10000, 8000);
        random_lists(330, 12);
        settle();

        // Near-impossible limits: almost every list ends in an error.
        apply_config(-1024, 1023, 1, 65535, 1);
        random_lists(150, 12);
        settle();

        // The long receiver hold-off falls in here; halfway the sender waits for all
        // owed routes before it goes on.
        apply_config(pick_coord(0, 2047), pick_coord(0, 2047), $urandom_range(20000, 2000000),
                     $urandom_range(1000, 30000), $urandom_range(0, 20000));
        random_lists(160, 12);
        settle();
        random_lists(170, 12);
        settle();

        // No length or service limit and the widest load limit: long lists whose length saturates.
        apply_config(0, 0, 0, 65535, 0);
        random_lists(400, 60);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            apply_config(pick_coord(0, 2047), pick_coord(0, 2047),
                         $urandom_range(20000, 3000000), $urandom_range(500, 65535),
                         $urandom_range(0, 30000));
            // The last stretch runs with neither side idling.
            if (p == 3)
                calm = 1'b1;
            random_lists(160, 16);
            settle();
        end

        if (pending_routes.size() != 0)
        begin
            err_count += pending_routes.size();
            $display("%0d route items never arrived", pending_routes.size());
        end
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
